>>> rtl/ujs_pkg.sv
// ----------------------------------------------------------------------------
// ujs_pkg
// Types and constants shared by the UTF-8 sanitizer for JSON-bound text.
// ----------------------------------------------------------------------------
package ujs_pkg;

  localparam int unsigned RunDepth = 4;          // most results caused by one byte
  localparam int unsigned RunCntW  = 3;          // holds 0 .. RunDepth
  localparam int unsigned RunIdxW  = 2;          // indexes the run slots

  localparam logic [7:0] QMARK     = 8'h3F;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_TAB  = 8'h09;
  localparam logic [7:0] BYTE_NUL  = 8'h00;
  localparam logic [7:0] BYTE_SP   = 8'd32;
  localparam logic [7:0] BYTE_DEL  = 8'd127;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       string_end;
    logic       last_of_run;
  } out_t;

  typedef logic [7:0] byte_run_t [RunDepth];

  // sequence length announced by a lead byte, two when it is none
  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] len;
    begin
      if ((lead & 8'hE0) == 8'hC0) begin
        len = 3'd2;
      end else if ((lead & 8'hF0) == 8'hE0) begin
        len = 3'd3;
      end else if ((lead & 8'hF8) == 8'hF0) begin
        len = 3'd4;
      end else begin
        len = 3'd2;
      end
      return len;
    end
  endfunction

  // lead of a 2-, 3- or 4-byte sequence
  function automatic logic is_lead(input logic [7:0] b);
    return ((b & 8'hE0) == 8'hC0) || ((b & 8'hF0) == 8'hE0) || ((b & 8'hF8) == 8'hF0);
  endfunction

  // 3-byte form lands in D800..DFFF: code point bits 15..11 are 11011
  function automatic logic is_surrogate(input logic [7:0] lead, input logic [7:0] cont);
    return ((lead & 8'h0F) == 8'h0D) && cont[5];
  endfunction

endpackage

>>> rtl/utf8_json_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_json_sanitizer
// Byte-wide UTF-8 cleaner for text bound for JSON: passes printable ASCII and
// whitespace, drops other controls, replaces bad bytes and surrogates by '?'.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | direction | payload
//  ---------+--------------------------------+-----------+------------------------
//  input    | in_valid, in_stall, in_data    | in        | in_byte, end_of_string
//  result   | out_valid, out_stall, out_data | out       | out_byte, string_end,
//           |                                |           | last_of_run
//
//  One byte per cycle enters the input register while in_stall is low; decode
//  loads its whole run (zero to four results) into the free run register, which
//  hands them out one per cycle while out_stall is low. A byte with several
//  results holds the run register until its last is taken; bytes with at most
//  one result each flow at one per cycle if nothing stalls. Reset (rst_n low,
//  synchronous) empties both registers; a result stall reaches in_stall at once.
//
module utf8_json_sanitizer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ujs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ujs_pkg::out_t out_data
);
  import ujs_pkg::*;

  // input register
  logic        in_vld_r;
  in_t         in_r;

  // held multi-byte sequence
  logic [7:0]  held_lead_r, held_lead_nxt;
  logic [7:0]  held_c1_r,   held_c1_nxt;
  logic [7:0]  held_c2_r,   held_c2_nxt;
  logic [1:0]  held_cnt_r,  held_cnt_nxt;

  // run register: the results of one byte, handed out in order
  byte_run_t            run_byte_r, run_byte_nxt;
  logic [RunCntW-1:0]   run_cnt_r,  run_cnt_nxt;
  logic [RunIdxW-1:0]   run_idx_r;
  logic                 run_term_r, run_term_nxt;

  logic        in_xfer;
  logic        out_xfer;
  logic        run_last;
  logic        run_free;
  logic        load;

  logic [7:0]  cur_byte;
  logic        is_end;
  logic        is_cont;
  logic [2:0]  need;
  logic [2:0]  have;

  assign cur_byte = in_r.in_byte;
  assign is_end   = in_r.end_of_string || (cur_byte == BYTE_NUL);
  assign is_cont  = (cur_byte & 8'hC0) == 8'h80;
  assign need     = seq_len(held_lead_r);
  assign have     = {1'b0, held_cnt_r} + 3'd1;

  // handshake
  assign out_valid = run_cnt_r != '0;
  assign run_last  = ({1'b0, run_idx_r} + 3'd1) == run_cnt_r;
  assign out_xfer  = out_valid && !out_stall;
  assign run_free  = !out_valid || (out_xfer && run_last);
  assign load      = in_vld_r && run_free;
  assign in_stall  = in_vld_r && !load;
  assign in_xfer   = in_valid && !in_stall;

  assign out_data.out_byte    = run_byte_r[run_idx_r];
  assign out_data.string_end  = run_term_r && run_last;
  assign out_data.last_of_run = run_last;

  // decode of one byte against the held sequence
  always_comb begin
    logic [1:0] flush;
    flush         = held_cnt_r;
    run_byte_nxt  = '{default: QMARK};
    run_cnt_nxt   = '0;
    run_term_nxt  = 1'b0;
    held_lead_nxt = held_lead_r;
    held_c1_nxt   = held_c1_r;
    held_c2_nxt   = held_c2_r;
    held_cnt_nxt  = held_cnt_r;

    if (is_end) begin
      // one '?' per held byte, then the terminator
      run_byte_nxt[flush] = BYTE_NUL;
      run_cnt_nxt         = {1'b0, flush} + 3'd1;
      run_term_nxt        = 1'b1;
      held_lead_nxt       = '0;
      held_c1_nxt         = '0;
      held_c2_nxt         = '0;
      held_cnt_nxt        = '0;
    end else if ((held_cnt_r != 2'd0) && is_cont) begin
      if (have < need) begin
        // keep collecting
        if (have == 3'd2) begin
          held_c1_nxt = cur_byte;
        end else begin
          held_c2_nxt = cur_byte;
        end
        held_cnt_nxt = have[1:0];
      end else begin
        case (need)
          3'd2: begin
            run_byte_nxt[0] = held_lead_r;
            run_byte_nxt[1] = cur_byte;
            run_cnt_nxt     = 3'd2;
          end
          3'd3: begin
            if (is_surrogate(held_lead_r, held_c1_r)) begin
              run_cnt_nxt = 3'd1;
            end else begin
              run_byte_nxt[0] = held_lead_r;
              run_byte_nxt[1] = held_c1_r;
              run_byte_nxt[2] = cur_byte;
              run_cnt_nxt     = 3'd3;
            end
          end
          default: begin
            run_byte_nxt[0] = held_lead_r;
            run_byte_nxt[1] = held_c1_r;
            run_byte_nxt[2] = held_c2_r;
            run_byte_nxt[3] = cur_byte;
            run_cnt_nxt     = 3'd4;
          end
        endcase
        held_lead_nxt = '0;
        held_c1_nxt   = '0;
        held_c2_nxt   = '0;
        held_cnt_nxt  = '0;
      end
    end else begin
      // broken sequence (if any) flushes as '?', then the byte starts afresh
      held_lead_nxt = '0;
      held_c1_nxt   = '0;
      held_c2_nxt   = '0;
      held_cnt_nxt  = '0;
      if (((cur_byte >= BYTE_SP) && (cur_byte < BYTE_DEL)) || (cur_byte == BYTE_LF) ||
          (cur_byte == BYTE_CR) || (cur_byte == BYTE_TAB)) begin
        run_byte_nxt[flush] = cur_byte;
        run_cnt_nxt         = {1'b0, flush} + 3'd1;
      end else if (cur_byte < BYTE_SP) begin
        run_cnt_nxt = {1'b0, flush};               // control byte dropped
      end else if (is_lead(cur_byte)) begin
        held_lead_nxt = cur_byte;
        held_cnt_nxt  = 2'd1;
        run_cnt_nxt   = {1'b0, flush};
      end else begin
        run_cnt_nxt = {1'b0, flush} + 3'd1;        // DEL, stray continuation, F8..FF
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
  end

  // held sequence and run control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_lead_r <= '0;
      held_c1_r   <= '0;
      held_c2_r   <= '0;
      held_cnt_r  <= '0;
      run_cnt_r   <= '0;
      run_idx_r   <= '0;
    end else begin
      if (load) begin
        held_lead_r <= held_lead_nxt;
        held_c1_r   <= held_c1_nxt;
        held_c2_r   <= held_c2_nxt;
        held_cnt_r  <= held_cnt_nxt;
        run_cnt_r   <= run_cnt_nxt;
        run_idx_r   <= '0;
      end else if (out_xfer) begin
        if (run_last) begin
          run_cnt_r <= '0;
          run_idx_r <= '0;
        end else begin
          run_idx_r <= run_idx_r + 2'd1;
        end
      end
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    if (load) begin
      run_byte_r <= run_byte_nxt;
      run_term_r <= run_term_nxt;
    end
  end

endmodule

>>> verif/tb_utf8_json_sanitizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_json_sanitizer
// Self-checking bench for the UTF-8 sanitizer. Byte streams go in through a
// queued driver. A behavioral copy of the cleaner predicts every output byte,
// and a monitor compares each result transfer with the oldest prediction.
// Traffic runs through several idle and stall mixes plus one long output
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_utf8_json_sanitizer;
  import ujs_pkg::*;

  localparam int unsigned IdleLimit   = 1000;  // cycles with no transfer at all
  localparam int unsigned DrainCycles = 8;     // padding after the last expected result
  localparam int unsigned HoldCycles  = 64;    // long output hold-off
  localparam int unsigned PhaseBytes  = 70;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  utf8_json_sanitizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  // raw bytes waiting for the driver, and cleaned bytes waiting for the dut
  in_t  raw_q[$];
  out_t clean_q[$];
  out_t run_q[$];      // results of the byte being predicted

  // idle mix, set per phase by the stimulus block
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;

  logic        in_took = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned bytes_in = 0;
  int unsigned results_seen = 0;
  int unsigned strings_seen = 0;
  int unsigned backpressure_cycles = 0;

  // predictor state: partly received multi-byte sequence
  logic [7:0] seq_lead  = '0;
  logic [7:0] seq_cont1 = '0;
  logic [7:0] seq_cont2 = '0;
  logic [1:0] seq_count = '0;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  task automatic emit_byte(input logic [7:0] b, input logic term);
    out_t r;
    begin
      r.out_byte    = b;
      r.string_end  = term;
      r.last_of_run = 1'b0;
      run_q.push_back(r);
    end
  endtask

  // every held byte turns into one question mark, then nothing is held
  task automatic flush_held();
    begin
      for (int i = 0; i < seq_count; i++) emit_byte(QMARK, 1'b0);
      seq_lead  = '0;
      seq_cont1 = '0;
      seq_cont2 = '0;
      seq_count = '0;
    end
  endtask

  // a byte seen with nothing held
  task automatic take_fresh(input logic [7:0] b);
    begin
      if (b >= BYTE_SP && b < BYTE_DEL) begin
        emit_byte(b, 1'b0);
      end else if (b == BYTE_LF || b == BYTE_CR || b == BYTE_TAB) begin
        emit_byte(b, 1'b0);
      end else if (b < BYTE_SP) begin
        // other control bytes vanish
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
        seq_lead  = b;
        seq_count = 2'd1;
      end else begin
        // del, stray continuation, f8..ff
        emit_byte(QMARK, 1'b0);
      end
    end
  endtask

  // works out all results of one accepted byte and queues them
  task automatic sanitize_byte(input in_t item);
    logic [7:0]  b;
    logic [15:0] cp;
    int          need;
    int          have;
    out_t        r;
    begin
      b = item.in_byte;
      if (item.end_of_string || b == BYTE_NUL) begin
        flush_held();
        emit_byte(8'h00, 1'b1);
      end else if (seq_count != 0 && b[7:6] == 2'b10) begin
        // continuation of the held sequence
        if (seq_lead[7:5] == 3'b110) need = 2;
        else if (seq_lead[7:4] == 4'b1110) need = 3;
        else if (seq_lead[7:3] == 5'b11110) need = 4;
        else need = 2;
        have = seq_count + 1;
        if (have < need) begin
          if (have == 2) seq_cont1 = b;
          else seq_cont2 = b;
          seq_count = 2'(have);
        end else begin
          case (need)
            2: begin
              emit_byte(seq_lead, 1'b0);
              emit_byte(b, 1'b0);
            end
            3: begin
              cp = {seq_lead[3:0], seq_cont1[5:0], b[5:0]};
              if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
                // surrogate halves are not valid scalar values
                emit_byte(QMARK, 1'b0);
              end else begin
                emit_byte(seq_lead, 1'b0);
                emit_byte(seq_cont1, 1'b0);
                emit_byte(b, 1'b0);
              end
            end
            default: begin
              emit_byte(seq_lead, 1'b0);
              emit_byte(seq_cont1, 1'b0);
              emit_byte(seq_cont2, 1'b0);
              emit_byte(b, 1'b0);
            end
          endcase
          seq_lead  = '0;
          seq_cont1 = '0;
          seq_cont2 = '0;
          seq_count = '0;
        end
      end else begin
        // broken sequence: held bytes go out as '?', byte starts over
        flush_held();
        take_fresh(b);
      end
      foreach (run_q[i]) begin
        r = run_q[i];
        r.last_of_run = (i == run_q.size() - 1);
        clean_q.push_back(r);
      end
      run_q.delete();
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus builders
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic eos);
    in_t item;
    begin
      item.in_byte       = b;
      item.end_of_string = eos;
      raw_q.push_back(item);
    end
  endtask

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // mostly well-formed text with random content, some broken and noisy bytes
  task automatic make_stream(input int unsigned count);
    int unsigned pick;
    int unsigned n;
    int unsigned goal;
    logic [7:0]  lead;
    begin
      n = 0;
      while (n < count) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          push_byte(8'($urandom_range(126, 32)), 1'b0);
          n++;
        end else if (pick < 35) begin
          case ($urandom_range(2))
            0: push_byte(BYTE_TAB, 1'b0);
            1: push_byte(BYTE_LF, 1'b0);
            default: push_byte(BYTE_CR, 1'b0);
          endcase
          n++;
        end else if (pick < 39) begin
          // control byte, usually dropped
          push_byte(8'($urandom_range(31, 1)), 1'b0);
        end else if (pick < 44) begin
          case ($urandom_range(2))
            0: push_byte(BYTE_DEL, 1'b0);
            1: push_byte(rand_cont(), 1'b0);
            default: push_byte(8'($urandom_range(255, 248)), 1'b0);
          endcase
          n++;
        end else if (pick < 56) begin
          push_byte(8'hC0 | 8'($urandom_range(31)), 1'b0);
          push_byte(rand_cont(), 1'b0);
          n += 2;
        end else if (pick < 68) begin
          if ($urandom_range(3) == 0) begin
            // lands in the surrogate range
            push_byte(8'hED, 1'b0);
            push_byte(8'hA0 | 8'($urandom_range(31)), 1'b0);
          end else begin
            push_byte(8'hE0 | 8'($urandom_range(15)), 1'b0);
            push_byte(rand_cont(), 1'b0);
          end
          push_byte(rand_cont(), 1'b0);
          n += 3;
        end else if (pick < 78) begin
          push_byte(8'hF0 | 8'($urandom_range(7)), 1'b0);
          push_byte(rand_cont(), 1'b0);
          push_byte(rand_cont(), 1'b0);
          push_byte(rand_cont(), 1'b0);
          n += 4;
        end else if (pick < 88) begin
          // truncated sequence, cut by a non-continuation byte or by end of string
          case ($urandom_range(2))
            0: begin lead = 8'hC0 | 8'($urandom_range(31)); goal = 0; end
            1: begin lead = 8'hE0 | 8'($urandom_range(15)); goal = $urandom_range(1); end
            default: begin lead = 8'hF0 | 8'($urandom_range(7)); goal = $urandom_range(2); end
          endcase
          push_byte(lead, 1'b0);
          for (int i = 0; i < goal; i++) push_byte(rand_cont(), 1'b0);
          case ($urandom_range(3))
            0: push_byte(8'hC0 | 8'($urandom_range(63)), 1'b0);
            1: push_byte(8'($urandom_range(255)), 1'b1);
            default: push_byte(8'($urandom_range(126, 32)), 1'b0);
          endcase
          n += goal + 2;
        end else if (pick < 94) begin
          // end of string by flag or by nul, sometimes mid-sequence
          if ($urandom_range(1) == 0) push_byte(8'hE0 | 8'($urandom_range(15)), 1'b0);
          if ($urandom_range(1) == 0) push_byte(8'($urandom_range(255)), 1'b1);
          else push_byte(BYTE_NUL, 1'b0);
          n += 2;
        end else begin
          push_byte(8'($urandom_range(255)), 1'($urandom_range(15) == 0));
          n++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // input driver: a new transfer is offered only after the last one went in
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_in
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (raw_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_data  <= raw_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall, with a long hold-off on request
  always @(negedge clk) begin : drive_stall
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predicts on input transfers, checks on result transfers
  // --------------------------------------------------------------------------
  task automatic report_diff(input string field, input int unsigned want, input int unsigned got);
    begin
      errors++;
      $display("%0t: mismatch in %s: expected 0x%02h, actual 0x%02h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    logic in_xfer;
    logic out_xfer;
    out_t want;
    in_xfer  = rst_n && in_valid && !in_stall;
    out_xfer = rst_n && out_valid && !out_stall;
    in_took <= in_xfer;
    if (rst_n && in_valid && in_stall) backpressure_cycles++;
    if (in_xfer) begin
      sanitize_byte(in_data);
      bytes_in++;
    end
    if (out_xfer) begin
      results_seen++;
      if (out_data.string_end) strings_seen++;
      if (clean_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual byte 0x%02h end %0b last %0b",
                 $time, out_data.out_byte, out_data.string_end, out_data.last_of_run);
      end else begin
        want = clean_q.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_diff("out_byte", want.out_byte, out_data.out_byte);
        if (out_data.string_end !== want.string_end)
          report_diff("string_end", want.string_end, out_data.string_end);
        if (out_data.last_of_run !== want.last_of_run)
          report_diff("last_of_run", want.last_of_run, out_data.last_of_run);
      end
    end
    if (in_xfer || out_xfer) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin : watchdog
    wait (idle_cycles >= IdleLimit);
    $display("%0t: no transfer for %0d cycles, %0d results still expected",
             $time, IdleLimit, clean_q.size());
    $display("tb_utf8_json_sanitizer failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus and phases
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: ascii edges, whitespace, dropped control, bad singles
    push_byte(8'h20, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(BYTE_TAB, 1'b0);
    push_byte(BYTE_LF, 1'b0);
    push_byte(BYTE_CR, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(BYTE_DEL, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    // complete two-byte, surrogate, complete four-byte
    push_byte(8'hC3, 1'b0);
    push_byte(8'hA9, 1'b0);
    push_byte(8'hED, 1'b0);
    push_byte(8'hA0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h9F, 1'b0);
    push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    // broken sequence, then end of string flushing three held bytes
    push_byte(8'hE2, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hF4, 1'b0);
    push_byte(8'h8F, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hA5, 1'b1);
    // nul ends an empty string
    push_byte(BYTE_NUL, 1'b0);
    wait (raw_q.size() == 0 && !in_valid);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 52; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 52; end
        3: begin snd_idle_pct = 7;  rcv_stall_pct = 7;  end
        default: begin
          // sender keeps offering while the result side holds off
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      make_stream(ph == 4 ? PhaseBytes / 2 : PhaseBytes);
      wait (raw_q.size() == 0 && !in_valid);
    end

    wait (clean_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d bytes in and %0d results out, %0d strings closed",
             bytes_in, results_seen, strings_seen);
    $display("input held back for %0d cycles across five idle/stall mixes",
             backpressure_cycles);
    if (errors == 0) begin
      $display("tb_utf8_json_sanitizer passed");
    end else begin
      $display("tb_utf8_json_sanitizer failed");
    end
    $finish;
  end

endmodule
